### design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [CfgIdxW-1:0] CfgBaudDivider = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgEnable = 1'd1;

  localparam logic [3:0] CmdNone = 4'd0;
  localparam logic [3:0] CmdStart = 4'd1;
  localparam logic [3:0] CmdRestart = 4'd2;
  localparam logic [3:0] CmdStop = 4'd3;
  localparam logic [3:0] CmdTransmit = 4'd4;
  localparam logic [3:0] CmdReceive = 4'd5;
  localparam logic [3:0] CmdAck = 4'd6;
  localparam logic [3:0] CmdReadBuf = 4'd7;
  localparam logic [3:0] CmdClearFlags = 4'd8;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       sda_in;
    logic       scl_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       nack_received;
    logic [7:0] rx_byte;
    logic       buffer_full;
    logic       write_collision;
  } out_item_t;

  // Classified tick handed from the front to the back.
  typedef struct packed {
    logic       is_op;
    logic       rd_buf;
    logic       clr_flags;
    logic [3:0] cmd;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       sda_in;
    logic       scl_in;
  } tick_t;

endpackage

### design/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input transfers, classifies the command and queues the tick.
// ----------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output tick_t    q_data
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  tick_t             mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     count;
  tick_t             cls;
  logic              push;
  logic              pop;

  always_comb begin
    cls.cmd = in_data.cmd;
    cls.tx_byte = in_data.tx_byte;
    cls.ack_bit = in_data.ack_bit;
    cls.sda_in = in_data.sda_in;
    cls.scl_in = in_data.scl_in;
    cls.is_op = (in_data.cmd >= CmdStart) && (in_data.cmd <= CmdAck);
    cls.rd_buf = (in_data.cmd == CmdReadBuf);
    cls.clr_flags = (in_data.cmd == CmdClearFlags);
  end

  assign in_ready = (count != (PtrW+1)'(Depth));
  assign q_valid = (count != '0);
  assign q_data = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

### design/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// Runs the bus sequencer one tick per queued item and registers the result.
// ----------------------------------------------------------------------------
module i2cm_back
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic       q_valid,
  output logic       q_ready,
  input  tick_t      q_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST_A  = 4'd1,
    PH_ST_B  = 4'd2,
    PH_RS_A  = 4'd3,
    PH_RS_B  = 4'd4,
    PH_SP_A  = 4'd6,
    PH_SP_B  = 4'd7,
    PH_SP_C  = 4'd8,
    PH_TX_LO = 4'd9,
    PH_TX_HI = 4'd10,
    PH_RX_LO = 4'd11,
    PH_RX_HI = 4'd12,
    PH_AK_LO = 4'd13,
    PH_AK_HI = 4'd14
  } phase_t;

  logic [7:0] baud_divider;
  logic       enable;
  phase_t     phase, phase_next;
  logic [7:0] baud_count, baud_count_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] rx_buffer, rx_buffer_next;
  logic [2:0] status_flags, status_flags_next;
  logic [1:0] line_drive, line_drive_next;
  logic       step;

  // Bit 0 of line_drive is SCL, bit 1 is SDA; flags are nack, full, collision.
  assign q_ready = !out_valid || out_ready;
  assign step = q_valid && q_ready;

  always_comb begin
    logic [7:0] sh;
    logic [3:0] bc;
    phase_next = phase;
    baud_count_next = baud_count;
    bit_count_next = bit_count;
    shift_reg_next = shift_reg;
    rx_buffer_next = rx_buffer;
    status_flags_next = status_flags;
    line_drive_next = line_drive;
    sh = '0;
    bc = '0;
    if (!enable) begin
      phase_next = PH_IDLE;
      line_drive_next = 2'b11;
      baud_count_next = '0;
      bit_count_next = '0;
    end else if (phase != PH_IDLE) begin
      if (q_data.is_op) begin
        status_flags_next[2] = 1'b1;
      end
      if (line_drive[0] && !q_data.scl_in) begin
        // Clock stretched by a slave: hold.
      end else if (baud_count != baud_divider) begin
        baud_count_next = baud_count + 8'd1;
      end else begin
        baud_count_next = '0;
        unique case (phase)
          PH_ST_A: begin phase_next = PH_ST_B; line_drive_next = 2'b01; end
          PH_ST_B: begin phase_next = PH_IDLE; line_drive_next = 2'b00; end
          PH_RS_A: begin phase_next = PH_RS_B; line_drive_next = 2'b11; end
          PH_RS_B: begin phase_next = PH_ST_B; line_drive_next = 2'b01; end
          PH_SP_A: begin phase_next = PH_SP_B; line_drive_next = 2'b01; end
          PH_SP_B: begin phase_next = PH_SP_C; line_drive_next = 2'b11; end
          PH_SP_C: begin phase_next = PH_IDLE; line_drive_next = 2'b11; end
          PH_TX_LO: begin
            phase_next = PH_TX_HI;
            line_drive_next = line_drive | 2'b01;
          end
          PH_TX_HI: begin
            if (bit_count >= 4'd8) begin
              status_flags_next[0] = q_data.sda_in;
              phase_next = PH_IDLE;
              line_drive_next = 2'b10;
            end else begin
              sh = {shift_reg[6:0], 1'b0};
              bc = bit_count + 4'd1;
              shift_reg_next = sh;
              bit_count_next = bc;
              phase_next = PH_TX_LO;
              line_drive_next = {(bc >= 4'd8) ? 1'b1 : sh[7], 1'b0};
            end
          end
          PH_RX_LO: begin phase_next = PH_RX_HI; line_drive_next = 2'b11; end
          PH_RX_HI: begin
            sh = {shift_reg[6:0], q_data.sda_in};
            bc = bit_count + 4'd1;
            shift_reg_next = sh;
            bit_count_next = bc;
            if (bc >= 4'd8) begin
              rx_buffer_next = sh;
              status_flags_next[1] = 1'b1;
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_RX_LO;
            end
            line_drive_next = 2'b10;
          end
          PH_AK_LO: begin
            phase_next = PH_AK_HI;
            line_drive_next = line_drive | 2'b01;
          end
          PH_AK_HI: begin
            phase_next = PH_IDLE;
            line_drive_next = line_drive & 2'b10;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end else if (q_data.is_op) begin
      baud_count_next = '0;
      unique case (q_data.cmd)
        CmdStart: begin phase_next = PH_ST_A; line_drive_next = 2'b11; end
        CmdRestart: begin phase_next = PH_RS_A; line_drive_next = 2'b10; end
        CmdStop: begin phase_next = PH_SP_A; line_drive_next = 2'b00; end
        CmdTransmit: begin
          shift_reg_next = q_data.tx_byte;
          bit_count_next = '0;
          phase_next = PH_TX_LO;
          line_drive_next = {q_data.tx_byte[7], 1'b0};
        end
        CmdReceive: begin
          shift_reg_next = '0;
          bit_count_next = '0;
          phase_next = PH_RX_LO;
          line_drive_next = 2'b10;
        end
        default: begin
          phase_next = PH_AK_LO;
          line_drive_next = {q_data.ack_bit, 1'b0};
        end
      endcase
    end
    if (q_data.rd_buf) begin
      status_flags_next[1] = 1'b0;
    end else if (q_data.clr_flags) begin
      status_flags_next[2] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baud_divider <= '0;
      enable <= 1'b0;
      phase <= PH_IDLE;
      baud_count <= '0;
      bit_count <= '0;
      shift_reg <= '0;
      rx_buffer <= '0;
      status_flags <= '0;
      line_drive <= 2'b11;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgBaudDivider: baud_divider <= cfg_data;
          CfgEnable: enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (step) begin
        phase <= phase_next;
        baud_count <= baud_count_next;
        bit_count <= bit_count_next;
        shift_reg <= shift_reg_next;
        rx_buffer <= rx_buffer_next;
        status_flags <= status_flags_next;
        line_drive <= line_drive_next;
        out_data.scl_release <= line_drive_next[0];
        out_data.sda_release <= line_drive_next[1];
        out_data.busy_res <= (phase_next != PH_IDLE);
        out_data.nack_received <= status_flags_next[0];
        out_data.rx_byte <= rx_buffer_next;
        out_data.buffer_full <= status_flags_next[1];
        out_data.write_collision <= status_flags_next[2];
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master byte engine with a decoupled command front and bus back end.
// ----------------------------------------------------------------------------
// Each input transfer is one tick of the bus engine and may carry a command
// (start, restart, stop, transmit, receive, ack, read buffer, clear flags).
// The front classifies the command and pushes the tick into a short queue;
// the back end advances the SCL/SDA sequencer by one tick per queued item
// and presents the line states and status flags as one output transfer.
// Throughput is one transfer per clock unless out_ready stalls the output;
// a tick passes the queue stage, then the output register. SCL phases last
// baud_divider+1 ticks, holding while a released SCL reads low. The user must
// write configuration via cfg_we/cfg_index/cfg_data only while idle (unchecked).
module i2c_master_byte_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  logic  q_valid;
  logic  q_ready;
  tick_t q_data;

  i2cm_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  i2cm_back u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );

  // An output transfer with no queued tick behind it leaves the output empty.
  a_out_empties: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !q_valid) |=> !out_valid)
    else $error("output valid without a new transfer");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> out_valid)
    else $error("queued tick produced no result");

  // A result waiting for the receiver stays valid and keeps its value.
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("waiting output transfer changed");

endmodule

### test/i2c_engine_checker.sv
// ----------------------------------------------------------------------------
// i2c_engine_checker
// Watches both channels of the I2C master byte engine, predicts the line
// states and status flags for every accepted tick and compares them in order.
// ----------------------------------------------------------------------------
module i2c_engine_checker
  import i2cm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_data,
  output int                  fail_count,
  output int                  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    Idle = 4'd0, StA = 4'd1, StB = 4'd2, RsA = 4'd3, RsB = 4'd4,
    SpA = 4'd6, SpB = 4'd7, SpC = 4'd8, TxLo = 4'd9, TxHi = 4'd10,
    RxLo = 4'd11, RxHi = 4'd12, AkLo = 4'd13, AkHi = 4'd14
  } bus_phase_e;

  logic [7:0] divider;
  logic       engine_on;
  bus_phase_e phase;
  logic [7:0] half_count;
  logic [3:0] bits_done;
  logic [7:0] shifter;
  logic [7:0] rx_buf;
  logic       nack_flag, full_flag, wcol_flag;
  logic       scl_rel, sda_rel;

  out_item_t expected_lines[$];

  assign pending_count = expected_lines.size();

  function automatic logic tx_bit_level();
    return (bits_done < 4'd8) ? shifter[7] : 1'b1;
  endfunction

  task automatic enter(bus_phase_e p, logic scl, logic sda);
    phase = p;
    scl_rel = scl;
    sda_rel = sda;
    half_count = '0;
  endtask

  // One baud tick of a running sequence, with clock stretching.
  task automatic tick_sequence(logic sda, logic scl);
    if (scl_rel && !scl) return;
    if (half_count != divider) begin
      half_count = half_count + 8'd1;
      return;
    end
    half_count = '0;
    case (phase)
      StA: enter(StB, 1'b1, 1'b0);
      StB: enter(Idle, 1'b0, 1'b0);
      RsA: enter(RsB, 1'b1, 1'b1);
      RsB: enter(StB, 1'b1, 1'b0);
      SpA: enter(SpB, 1'b1, 1'b0);
      SpB: enter(SpC, 1'b1, 1'b1);
      SpC: enter(Idle, 1'b1, 1'b1);
      TxLo: enter(TxHi, 1'b1, sda_rel);
      TxHi: begin
        if (bits_done >= 4'd8) begin
          nack_flag = sda;
          enter(Idle, 1'b0, 1'b1);
        end else begin
          shifter = shifter << 1;
          bits_done = bits_done + 4'd1;
          enter(TxLo, 1'b0, tx_bit_level());
        end
      end
      RxLo: enter(RxHi, 1'b1, 1'b1);
      RxHi: begin
        shifter = {shifter[6:0], sda};
        bits_done = bits_done + 4'd1;
        if (bits_done >= 4'd8) begin
          rx_buf = shifter;
          full_flag = 1'b1;
          enter(Idle, 1'b0, 1'b1);
        end else begin
          enter(RxLo, 1'b0, 1'b1);
        end
      end
      AkLo: enter(AkHi, 1'b1, sda_rel);
      AkHi: enter(Idle, 1'b0, sda_rel);
      default: enter(Idle, scl_rel, sda_rel);
    endcase
  endtask

  task automatic predict_tick(in_item_t it);
    logic is_cmd;
    out_item_t r;
    is_cmd = (it.cmd >= CmdStart) && (it.cmd <= CmdAck);
    if (!engine_on) begin
      phase = Idle;
      scl_rel = 1'b1;
      sda_rel = 1'b1;
      half_count = '0;
      bits_done = '0;
    end else if (phase != Idle) begin
      tick_sequence(it.sda_in, it.scl_in);
      if (is_cmd) wcol_flag = 1'b1;
    end else if (is_cmd) begin
      case (it.cmd)
        CmdStart: enter(StA, 1'b1, 1'b1);
        CmdRestart: enter(RsA, 1'b0, 1'b1);
        CmdStop: enter(SpA, 1'b0, 1'b0);
        CmdTransmit: begin
          shifter = it.tx_byte;
          bits_done = '0;
          enter(TxLo, 1'b0, tx_bit_level());
        end
        CmdReceive: begin
          shifter = '0;
          bits_done = '0;
          enter(RxLo, 1'b0, 1'b1);
        end
        default: enter(AkLo, 1'b0, it.ack_bit);
      endcase
    end
    if (it.cmd == CmdReadBuf) full_flag = 1'b0;
    else if (it.cmd == CmdClearFlags) wcol_flag = 1'b0;
    r.scl_release = scl_rel;
    r.sda_release = sda_rel;
    r.busy_res = (phase != Idle);
    r.nack_received = nack_flag;
    r.rx_byte = rx_buf;
    r.buffer_full = full_flag;
    r.write_collision = wcol_flag;
    expected_lines.push_back(r);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      divider <= '0;
      engine_on <= 1'b0;
      phase = Idle;
      half_count = '0;
      bits_done = '0;
      shifter = '0;
      rx_buf = '0;
      nack_flag = 1'b0;
      full_flag = 1'b0;
      wcol_flag = 1'b0;
      scl_rel = 1'b1;
      sda_rel = 1'b1;
      expected_lines.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgBaudDivider) divider <= cfg_data;
        else if (cfg_index == CfgEnable) engine_on <= cfg_data[0];
      end
      if (in_valid && in_ready) predict_tick(in_data);
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: unexpected transfer, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_lines.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  // The queue is popped in the same clocked block that checks the output, so
  // an output transfer can never be compared against a tick of the same edge.
  // The design's queue stage and output register keep that ordering safe.
endmodule

### test/tb_i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine
// Drives directed and random ticks into the I2C master byte engine across
// several divider and enable settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 5000;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  int                  fail_count;
  int                  pending_count;
  int                  idle_cycles;
  logic                stall_enable;

  i2c_master_byte_engine DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  i2c_engine_checker checker_inst (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // The receiver draws a fresh stall length for every output transfer. While
  // stalls are switched off, ready stays high so there are stretches of
  // back-to-back transfers as well.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      gap = stall_enable ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Any cycle with no transfer on either channel counts toward the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb_i2c_master_byte_engine NOT OK");
        $finish;
      end
    end
  end

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hands one tick to the engine after a random gap, holding it until the
  // transfer happens. Valid is lowered only when there is a gap to take.
  task automatic send_tick(logic [3:0] cmd, logic [7:0] tx, logic ackb, logic sda,
                           logic scl, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: cmd, tx_byte: tx, ack_bit: ackb, sda_in: sda, scl_in: scl};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Waits until every predicted transfer has arrived, then lets the pipeline
  // settle before a register write.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random tick: mostly no command, with realistic bus levels and
  // occasional stretching. Commands land at random, so some collide.
  task automatic send_random_tick(bit gaps);
    logic [3:0] cmd;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) cmd = CmdNone;
    else if (pick < 90) cmd = 4'($urandom_range(CmdStart, CmdAck));
    else if (pick < 97) cmd = 4'($urandom_range(CmdReadBuf, CmdClearFlags));
    else cmd = 4'($urandom_range(9, 15));
    send_tick(cmd, 8'($urandom), 1'($urandom), 1'($urandom),
              ($urandom_range(0, 9) != 0), gaps);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    stall_enable = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Engine still disabled: commands must not move the lines, but read
    // buffer and clear flags still act.
    for (int c = 0; c < 16; c++) send_tick(4'(c), 8'hA5, 1'b1, 1'b0, 1'b1, 1'b1);
    drain_results();

    // Divider at zero: every operation back to back, extremes of the byte,
    // stretching and a command arriving while busy.
    write_register(CfgEnable, 8'd1);
    write_register(CfgBaudDivider, 8'd0);
    send_tick(CmdStart, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
    repeat (4) send_tick(CmdNone, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
    send_tick(CmdTransmit, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b0);
    send_tick(CmdReceive, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
    for (int i = 0; i < 20; i++) send_tick(CmdNone, 8'h00, 1'b0, 1'b0, i != 3, 1'b0);
    send_tick(CmdTransmit, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < 20; i++) send_tick(CmdNone, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
    send_tick(CmdAck, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0);
    send_tick(CmdRestart, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    repeat (4) send_tick(CmdNone, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(CmdClearFlags, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    send_tick(CmdStop, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    drain_results();

    // Random phases at several dividers, including both extremes; the large
    // divider gets only a short burst since each half period is 256 ticks.
    for (int ph = 0; ph < 6; ph++) begin
      int count;
      logic [7:0] div;
      case (ph)
        0: div = 8'd0;
        1: div = 8'd1;
        2: div = 8'd255;
        3: div = 8'($urandom_range(2, 5));
        4: div = 8'd0;
        default: div = 8'd3;
      endcase
      write_register(CfgBaudDivider, div);
      write_register(CfgEnable, (ph == 4) ? 8'd0 : 8'd1);
      stall_enable = (ph != 1);
      count = (ph == 2) ? 40 : 80;
      for (int i = 0; i < count; i++) begin
        send_random_tick(ph != 1 && ph != 3);
        // Hold off once until every expected result has come back.
        if (ph == 0 && i == 40) drain_results();
      end
      drain_results();
    end

    write_register(CfgEnable, 8'd1);
    if (fail_count == 0) begin
      $display("tb_i2c_master_byte_engine OK");
    end else begin
      $display("tb_i2c_master_byte_engine NOT OK");
    end
    $finish;
  end
endmodule

### i2c_master_byte_engine.f
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_back.sv
design/i2c_master_byte_engine.sv
test/i2c_engine_checker.sv
test/tb_i2c_master_byte_engine.sv
